FILE: rtl/watm_pkg.sv
// Shared types and constants for the wildcard address table match unit.
// No dependencies.
`timescale 1ns / 1ps

package watm_pkg;

	localparam int unsigned PART_W  = 16;
	localparam int unsigned ENTRY_W = 4 * PART_W;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned TIER_W  = 3;

	localparam logic [PART_W-1:0] WILD_PART = 16'hffff;

	localparam logic [KIND_W-1:0] KIND_EXACT_THEN_WILD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXACT_ONLY      = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WILD_ONLY       = 2'd2;

	localparam logic [TIER_W-1:0] TIER_EXACT      = 3'd0;
	localparam logic [TIER_W-1:0] TIER_POINT_WILD = 3'd1;
	localparam logic [TIER_W-1:0] TIER_NODE_WILD  = 3'd2;
	localparam logic [TIER_W-1:0] TIER_NET_WILD   = 3'd3;
	localparam logic [TIER_W-1:0] TIER_ALL_WILD   = 3'd4;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic              hit;
		logic [TIER_W-1:0] tier;
	} tier_res_t;

endpackage

FILE: rtl/watm_tier.sv
// Tier compare for one stored entry against the lookup key.
// Depends on watm_pkg.
`timescale 1ns / 1ps

module watm_tier (
	input  logic [watm_pkg::ENTRY_W-1:0] entry,
	input  logic [watm_pkg::ENTRY_W-1:0] key,
	input  logic [watm_pkg::KIND_W-1:0]  kind,
	output watm_pkg::tier_res_t          res
);
	import watm_pkg::*;

	logic eq_zone, eq_net, eq_node, eq_point;
	logic wild_zone, wild_net, wild_node, wild_point;
	logic allow_exact, allow_wild;

	assign eq_zone  = entry[4*PART_W-1:3*PART_W] == key[4*PART_W-1:3*PART_W];
	assign eq_net   = entry[3*PART_W-1:2*PART_W] == key[3*PART_W-1:2*PART_W];
	assign eq_node  = entry[2*PART_W-1:PART_W]   == key[2*PART_W-1:PART_W];
	assign eq_point = entry[PART_W-1:0]          == key[PART_W-1:0];

	assign wild_zone  = entry[4*PART_W-1:3*PART_W] == WILD_PART;
	assign wild_net   = entry[3*PART_W-1:2*PART_W] == WILD_PART;
	assign wild_node  = entry[2*PART_W-1:PART_W]   == WILD_PART;
	assign wild_point = entry[PART_W-1:0]          == WILD_PART;

	// kind 3 behaves as exact only
	assign allow_exact = kind != KIND_WILD_ONLY;
	assign allow_wild  = (kind == KIND_EXACT_THEN_WILD) || (kind == KIND_WILD_ONLY);

	always_comb begin
		res.hit  = 1'b1;
		res.tier = TIER_EXACT;
		if (allow_exact && eq_zone && eq_net && eq_node && eq_point) begin
			res.tier = TIER_EXACT;
		end else if (allow_wild && wild_point && eq_zone && eq_net && eq_node) begin
			res.tier = TIER_POINT_WILD;
		end else if (allow_wild && wild_node && eq_zone && eq_net) begin
			res.tier = TIER_NODE_WILD;
		end else if (allow_wild && wild_net && eq_zone) begin
			res.tier = TIER_NET_WILD;
		end else if (allow_wild && wild_zone) begin
			res.tier = TIER_ALL_WILD;
		end else begin
			res.hit  = 1'b0;
			res.tier = TIER_EXACT;
		end
	end

endmodule

FILE: rtl/wildcard_address_table_match_unit.sv
// Top level of the wildcard address table match unit: table memory, scan sequencer,
// output register. Depends on watm_pkg and watm_tier.
`timescale 1ns / 1ps

// Channel  Signals                              Direction
// in       in_valid/in_stall + input fields     into block
// out      out_valid/out_stall + match fields   out of block
// cfg      cfg_write/cfg_data (entry_count)     into block
//
// A write transaction does not raise in_stall. A lookup scans the table once through one
// registered memory read port and one tier comparator, over min(entry_count, TABLE_DEPTH)
// entries. in_stall is high for the whole scan and while a finished result waits for the
// output register. arst_n clears control state and entry_count; the table itself holds no
// reset value.

module wildcard_address_table_match_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [watm_pkg::CNT_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [watm_pkg::IDX_W-1:0]   entry_index,
	input  logic [watm_pkg::PART_W-1:0]  addr_zone,
	input  logic [watm_pkg::PART_W-1:0]  addr_net,
	input  logic [watm_pkg::PART_W-1:0]  addr_node,
	input  logic [watm_pkg::PART_W-1:0]  addr_point,
	input  logic [watm_pkg::KIND_W-1:0]  match_kind,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [watm_pkg::CNT_W-1:0]   match_index,
	output logic                         match_found,
	output logic [watm_pkg::TIER_W-1:0]  match_tier
);
	import watm_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = IW + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

	state_t             state_q;
	logic [CNT_W-1:0]   entry_count_q;
	logic [ENTRY_W-1:0] key_q;
	logic [KIND_W-1:0]  kind_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      issue_q;
	logic               rd_valid_q;
	logic [CW-1:0]      rd_idx_q;
	logic [ENTRY_W-1:0] rd_data_q;
	logic               best_hit_q;
	logic [TIER_W-1:0]  best_tier_q;
	logic [CW-1:0]      best_idx_q;
	logic               out_valid_q;
	logic [CNT_W-1:0]   match_index_q;
	logic               match_found_q;
	logic [TIER_W-1:0]  match_tier_q;

	logic               in_accept;
	logic [ENTRY_W-1:0] in_key;
	logic [CW-1:0]      eff_cnt;
	logic               wr_en;
	logic               rd_en;
	tier_res_t          cmp_res;

	assign in_stall  = state_q != ST_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign in_key    = {addr_zone, addr_net, addr_node, addr_point};
	assign eff_cnt   = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
	                                                           : CW'(entry_count_q);
	assign wr_en     = in_accept && (mode == MODE_WRITE) &&
	                   (32'(entry_index) < 32'(TABLE_DEPTH));
	assign rd_en     = (state_q == ST_SCAN) && (issue_q < cnt_q);

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[IW'(entry_index)] <= in_key;
		end
		if (rd_en) begin
			rd_data_q <= mem[issue_q[IW-1:0]];
		end
	end

	watm_tier u_tier (
		.entry (rd_data_q),
		.key   (key_q),
		.kind  (kind_q),
		.res   (cmp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_write) begin
			entry_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			best_hit_q  <= 1'b0;
			issue_q     <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_valid_q <= 1'b0;
					if (in_accept && (mode == MODE_LOOKUP)) begin
						key_q      <= in_key;
						kind_q     <= match_kind;
						cnt_q      <= eff_cnt;
						issue_q    <= '0;
						best_hit_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_valid_q <= rd_en;
					rd_idx_q   <= issue_q;
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					// strict compare keeps the lowest index within a tier
					if (rd_valid_q && cmp_res.hit &&
					    (!best_hit_q || (cmp_res.tier < best_tier_q))) begin
						best_hit_q  <= 1'b1;
						best_tier_q <= cmp_res.tier;
						best_idx_q  <= rd_idx_q;
					end
					if (!rd_en && !rd_valid_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						match_found_q <= best_hit_q;
						match_index_q <= best_hit_q ? CNT_W'(best_idx_q) : CNT_W'(cnt_q);
						match_tier_q  <= best_hit_q ? best_tier_q : TIER_EXACT;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign match_index = match_index_q;
	assign match_found = match_found_q;
	assign match_tier  = match_tier_q;

	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished scan");

	a_miss_tier_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !match_found) |-> (match_tier == TIER_EXACT))
		else $error("miss reported with nonzero tier");

	a_read_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rd_valid_q) |-> (rd_idx_q < cnt_q))
		else $error("scan read beyond entry count");

	a_hit_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match_found) |-> (32'(match_index) < 32'(TABLE_DEPTH)))
		else $error("match index outside table");

endmodule

FILE: test/testbench.sv
// Testbench for wildcard_address_table_match_unit: directed table walk, then random
// write/lookup traffic checked against a tier-search predictor. Depends on watm_pkg.
`timescale 1ns / 1ps

module testbench;
	import watm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_EXACT_ALIAS = 2'd3;
	localparam logic [TIER_W-1:0] MISS_TIER = 3'd0;
	localparam int DEPTH = 64;
	localparam int SETTLE = DEPTH + 16;
	localparam int PHASE_ITEMS = 196;
	localparam longint CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [CNT_W-1:0]  index;
		logic              found;
		logic [TIER_W-1:0] tier;
	} match_t;

	typedef struct packed {
		logic               is_cfg;
		logic               m;
		logic [IDX_W-1:0]   slot;
		logic [CNT_W-1:0]   count;
		logic [ENTRY_W-1:0] key;
		logic [KIND_W-1:0]  kind;
		match_t             want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic [CNT_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [IDX_W-1:0]   entry_index;
	logic [PART_W-1:0]  addr_zone;
	logic [PART_W-1:0]  addr_net;
	logic [PART_W-1:0]  addr_node;
	logic [PART_W-1:0]  addr_point;
	logic [KIND_W-1:0]  match_kind;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CNT_W-1:0]   match_index;
	logic               match_found;
	logic [TIER_W-1:0]  match_tier;

	logic [ENTRY_W-1:0] route_table [DEPTH];
	logic [CNT_W-1:0]   used_entries = '0;
	match_t             pending_matches [$];
	match_t             seen_match;
	match_t             oldest_match;
	int                 send_idle = 26;
	int                 recv_idle = 60;
	int                 mismatches = 0;
	longint             cycles = 0;

	wildcard_address_table_match_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.entry_index (entry_index),
		.addr_zone   (addr_zone),
		.addr_net    (addr_net),
		.addr_node   (addr_node),
		.addr_point  (addr_point),
		.match_kind  (match_kind),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_index (match_index),
		.match_found (match_found),
		.match_tier  (match_tier)
	);

	always #2 clk = ~clk;

	function automatic match_t best_match(input logic [ENTRY_W-1:0] key,
			input logic [KIND_W-1:0] kind);
		match_t r;
		int n;
		logic [ENTRY_W-1:0] e;
		bit hit;
		n = (used_entries > DEPTH) ? DEPTH : used_entries;
		r.index = CNT_W'(n);
		r.found = 1'b0;
		r.tier = MISS_TIER;
		if (kind != KIND_WILD_ONLY) begin
			for (int i = 0; i < n && !r.found; i++) begin
				if (route_table[i] == key) begin
					r.index = CNT_W'(i);
					r.found = 1'b1;
					r.tier = TIER_EXACT;
				end
			end
		end
		if (!r.found && (kind == KIND_EXACT_THEN_WILD || kind == KIND_WILD_ONLY)) begin
			for (int t = TIER_POINT_WILD; t <= TIER_ALL_WILD && !r.found; t++) begin
				for (int i = 0; i < n && !r.found; i++) begin
					e = route_table[i];
					case (TIER_W'(t))
					TIER_POINT_WILD: hit = e[15:0] == WILD_PART && e[63:16] == key[63:16];
					TIER_NODE_WILD:  hit = e[31:16] == WILD_PART && e[63:32] == key[63:32];
					TIER_NET_WILD:   hit = e[47:32] == WILD_PART && e[63:48] == key[63:48];
					default:         hit = e[63:48] == WILD_PART;
					endcase
					if (hit) begin
						r.index = CNT_W'(i);
						r.found = 1'b1;
						r.tier = TIER_W'(t);
					end
				end
			end
		end
		return r;
	endfunction

	// mostly tiny values so entries collide and tiers compete
	function automatic logic [PART_W-1:0] pick_part();
		if ($urandom_range(0, 3) != 0)
			return PART_W'($urandom_range(0, 3));
		return PART_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [ENTRY_W-1:0] random_entry();
		logic [PART_W-1:0] p [4];
		for (int k = 0; k < 4; k++)
			p[k] = pick_part();
		case ($urandom_range(0, 5))
		1: p[3] = WILD_PART;
		2: p[2] = WILD_PART;
		3: p[1] = WILD_PART;
		4: p[0] = WILD_PART;
		5: begin
			for (int k = 0; k < 4; k++)
				if ($urandom_range(0, 3) == 0)
					p[k] = WILD_PART;
		end
		default: ;
		endcase
		return {p[0], p[1], p[2], p[3]};
	endfunction

	// lookup address mostly derived from a live entry, wildcards filled in
	function automatic logic [ENTRY_W-1:0] random_key();
		logic [ENTRY_W-1:0] k;
		int n;
		n = (used_entries > DEPTH) ? DEPTH : used_entries;
		if (n == 0 || $urandom_range(0, 9) < 3)
			return {pick_part(), pick_part(), pick_part(), pick_part()};
		k = route_table[$urandom_range(0, n - 1)];
		for (int j = 0; j < 4; j++)
			if (k[16*j +: 16] == WILD_PART && $urandom_range(0, 3) != 0)
				k[16*j +: 16] = pick_part();
		if ($urandom_range(0, 3) == 0)
			k[16*$urandom_range(0, 3) +: 16] = pick_part();
		return k;
	endfunction

	function automatic row_t mk(input logic is_cfg, input logic m, input int slot,
			input int count, input logic [ENTRY_W-1:0] key, input logic [KIND_W-1:0] kind,
			input int idx, input logic fnd, input logic [TIER_W-1:0] tier);
		row_t r;
		r.is_cfg = is_cfg;
		r.m = m;
		r.slot = IDX_W'(slot);
		r.count = CNT_W'(count);
		r.key = key;
		r.kind = kind;
		r.want.index = CNT_W'(idx);
		r.want.found = fnd;
		r.want.tier = tier;
		return r;
	endfunction

	task automatic offer(input logic m, input logic [IDX_W-1:0] slot,
			input logic [ENTRY_W-1:0] key, input logic [KIND_W-1:0] kind,
			input logic typed, input match_t want);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < send_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode <= m;
		entry_index <= slot;
		{addr_zone, addr_net, addr_node, addr_point} <= key;
		match_kind <= kind;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (m == MODE_WRITE)
			route_table[slot] = key;
		else
			pending_matches.push_back(typed ? want : best_match(key, kind));
		@(negedge clk);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_matches.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_count(input logic [CNT_W-1:0] v);
		pause_until_drained();
		repeat (SETTLE) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		used_entries = v;
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_match = {match_index, match_found, match_tier};
			if (pending_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: index %0d found %0d tier %0d",
						match_index, match_found, match_tier);
			end else begin
				oldest_match = pending_matches.pop_front();
				if (seen_match.index !== oldest_match.index ||
						seen_match.found !== oldest_match.found ||
						seen_match.tier !== oldest_match.tier) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected index %0d found %0d tier %0d, got %0d %0d %0d",
							oldest_match.index, oldest_match.found, oldest_match.tier,
							seen_match.index, seen_match.found, seen_match.tier);
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		logic [CNT_W-1:0] phase_counts [9];
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_WRITE;
		entry_index = '0;
		addr_zone = '0;
		addr_net = '0;
		addr_node = '0;
		addr_point = '0;
		match_kind = KIND_EXACT_THEN_WILD;
		phase_counts = '{7'd64, 7'd127, 7'd0, 7'd65, 7'd1, 7'd33, 7'd64, 7'd7, 7'd100};

		// empty table after reset: miss at index 0
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0003_0004,
			KIND_EXACT_THEN_WILD, 0, 0, MISS_TIER));
		rows.push_back(mk(0, MODE_WRITE, 0, 0, 64'h0001_0002_0003_0004, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_WRITE, 1, 0, 64'h0001_0002_0003_ffff, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_WRITE, 2, 0, 64'h0001_0002_ffff_0009, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_WRITE, 3, 0, 64'h0001_ffff_0005_0006, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_WRITE, 4, 0, 64'hffff_0007_0008_0009, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_WRITE, 5, 0, 64'h0001_0002_0003_0004, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_WRITE, 6, 0, 64'hffff_ffff_ffff_ffff, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_WRITE, 7, 0, 64'h0000_0000_0000_0000, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(1, MODE_WRITE, 0, 8, '0, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0003_0004,
			KIND_EXACT_THEN_WILD, 0, 1, TIER_EXACT));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0003_0004,
			KIND_EXACT_ONLY, 0, 1, TIER_EXACT));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0003_0004,
			KIND_WILD_ONLY, 1, 1, TIER_POINT_WILD));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0003_0005,
			KIND_EXACT_THEN_WILD, 1, 1, TIER_POINT_WILD));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0003_0005,
			KIND_EXACT_ONLY, 8, 0, MISS_TIER));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0003_0005,
			KIND_EXACT_ALIAS, 8, 0, MISS_TIER));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0002_0007_0007,
			KIND_EXACT_THEN_WILD, 2, 1, TIER_NODE_WILD));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0001_0009_0009_0009,
			KIND_EXACT_THEN_WILD, 3, 1, TIER_NET_WILD));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0005_0005_0005_0005,
			KIND_EXACT_THEN_WILD, 4, 1, TIER_ALL_WILD));
		// all-ones lookup address is a plain value, not a wildcard
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'hffff_ffff_ffff_ffff,
			KIND_EXACT_THEN_WILD, 6, 1, TIER_EXACT));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'hffff_ffff_ffff_ffff,
			KIND_WILD_ONLY, 6, 1, TIER_POINT_WILD));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0000_0000_0000_0000,
			KIND_EXACT_ONLY, 7, 1, TIER_EXACT));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0000_0000_0000_0000,
			KIND_WILD_ONLY, 4, 1, TIER_ALL_WILD));
		rows.push_back(mk(1, MODE_WRITE, 0, 1, '0, KIND_EXACT_ONLY, 0, 0, 0));
		rows.push_back(mk(0, MODE_LOOKUP, 0, 0, 64'h0005_0005_0005_0005,
			KIND_EXACT_THEN_WILD, 1, 0, MISS_TIER));

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				set_count(rows[i].count);
			else
				offer(rows[i].m, rows[i].slot, rows[i].key, rows[i].kind,
					rows[i].m == MODE_LOOKUP, rows[i].want);
		end

		// every slot written before any count reaches it
		for (int s = 0; s < DEPTH; s++)
			offer(MODE_WRITE, IDX_W'(s), random_entry(), KIND_EXACT_THEN_WILD, 1'b0, '0);

		for (int ph = 0; ph < 9; ph++) begin
			send_idle = (ph < 3) ? 26 : (ph < 6) ? 60 : 0;
			recv_idle = (ph < 3) ? 60 : (ph < 6) ? 26 : 0;
			set_count(phase_counts[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 49) == 0)
					pause_until_drained();
				if ($urandom_range(0, 99) < 35)
					offer(MODE_WRITE, IDX_W'($urandom_range(0, DEPTH - 1)), random_entry(),
						KIND_W'($urandom_range(0, 3)), 1'b0, '0);
				else
					offer(MODE_LOOKUP, IDX_W'($urandom_range(0, DEPTH - 1)), random_key(),
						KIND_W'($urandom_range(0, 3)), 1'b0, '0);
			end
		end

		pause_until_drained();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/watm_pkg.sv
rtl/watm_tier.sv
rtl/wildcard_address_table_match_unit.sv
test/testbench.sv
